// File: src/i2cm_pkg.sv
// i2cm_pkg: command codes, queue entry type and phase decode functions
// for the i2c master byte sequencer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_RSTART = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    localparam int IDX_W = 6;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_RSTART,
        CMD_WRITE,
        CMD_READ,
        CMD_STOP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ACT_SDA,
        ACT_SCL,
        ACT_DIR
    } act_kind_t;

    typedef struct packed {
        act_kind_t kind;
        logic      value;
        logic      sample;
    } act_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       data_byte;
        logic             nak_last;
        logic [7:0]       line_samples;
        logic [IDX_W-1:0] last_idx;
    } cmd_t;

    // index of the final phase of each command's run
    function automatic logic [IDX_W-1:0] phase_last(cmd_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            CMD_START:  n = IDX_W'(31);
            CMD_RSTART: n = IDX_W'(33);
            CMD_WRITE:  n = IDX_W'(29);
            CMD_READ:   n = IDX_W'(22);
            CMD_STOP:   n = IDX_W'(2);
            default:    n = '0;
        endcase
        return n;
    endfunction

    // eight data bits (sda, scl high, scl low) then the acknowledge slot
    function automatic act_t octet_action(logic [IDX_W-1:0] j, logic [7:0] byte_v);
        act_t a;
        a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
        if (j < IDX_W'(24))
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (j == IDX_W'(3 * b))
                    a = '{kind: ACT_SDA, value: byte_v[3'(7 - b)], sample: 1'b0};
                else if (j == IDX_W'(3 * b + 1))
                    a = '{kind: ACT_SCL, value: 1'b1, sample: 1'b0};
                else if (j == IDX_W'(3 * b + 2))
                    a = '{kind: ACT_SCL, value: 1'b0, sample: 1'b0};
            end
        end
        else
        begin
            case (j)
                IDX_W'(24): a = '{kind: ACT_DIR, value: 1'b0, sample: 1'b0};
                IDX_W'(25): a = '{kind: ACT_SDA, value: 1'b1, sample: 1'b0};
                IDX_W'(26): a = '{kind: ACT_SCL, value: 1'b1, sample: 1'b1};
                IDX_W'(27): a = '{kind: ACT_SCL, value: 1'b0, sample: 1'b0};
                IDX_W'(28): a = '{kind: ACT_DIR, value: 1'b1, sample: 1'b0};
                default:    a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
            endcase
        end
        return a;
    endfunction

    function automatic act_t phase_action(cmd_kind_t kind, logic [IDX_W-1:0] idx,
                                          logic [7:0] byte_v, logic nak);
        act_t a;
        a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
        case (kind)
            CMD_START:
            begin
                if (idx == IDX_W'(0))
                    a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
                else if (idx == IDX_W'(1))
                    a = '{kind: ACT_SCL, value: 1'b0, sample: 1'b0};
                else
                    a = octet_action(idx - IDX_W'(2), byte_v);
            end
            CMD_RSTART:
            begin
                if (idx == IDX_W'(0))
                    a = '{kind: ACT_SDA, value: 1'b1, sample: 1'b0};
                else if (idx == IDX_W'(1))
                    a = '{kind: ACT_SCL, value: 1'b1, sample: 1'b0};
                else if (idx == IDX_W'(2))
                    a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
                else if (idx == IDX_W'(3))
                    a = '{kind: ACT_SCL, value: 1'b0, sample: 1'b0};
                else
                    a = octet_action(idx - IDX_W'(4), byte_v);
            end
            CMD_WRITE:
                a = octet_action(idx, byte_v);
            CMD_READ:
            begin
                if (idx == IDX_W'(0))
                    a = '{kind: ACT_SDA, value: 1'b1, sample: 1'b0};
                else if (idx == IDX_W'(1))
                    a = '{kind: ACT_DIR, value: 1'b0, sample: 1'b0};
                else if (idx < IDX_W'(18))
                    // even phases sample with scl high, odd phases pull scl low
                    a = '{kind: ACT_SCL, value: ~idx[0], sample: ~idx[0]};
                else if (idx == IDX_W'(18))
                    a = '{kind: ACT_DIR, value: 1'b1, sample: 1'b0};
                else if (idx == IDX_W'(19))
                    a = '{kind: ACT_SDA, value: nak, sample: 1'b0};
                else if (idx == IDX_W'(20))
                    a = '{kind: ACT_SCL, value: 1'b1, sample: 1'b0};
                else if (idx == IDX_W'(21))
                    a = '{kind: ACT_SCL, value: 1'b0, sample: 1'b0};
                else
                    a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
            end
            CMD_STOP:
            begin
                if (idx == IDX_W'(0))
                    a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
                else if (idx == IDX_W'(1))
                    a = '{kind: ACT_SCL, value: 1'b1, sample: 1'b0};
                else
                    a = '{kind: ACT_SDA, value: 1'b1, sample: 1'b0};
            end
            default:
                a = '{kind: ACT_SDA, value: 1'b0, sample: 1'b0};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: src/i2cm_front.sv
// i2cm_front: accepts bus commands, decodes the opcode and queues them
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   data_byte,
    input  wire logic         nak_last,
    input  wire logic [7:0]   line_samples,
    output logic              q_valid,
    output i2cm_pkg::cmd_t    q_head,
    input  wire logic         q_pop
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             op_ok;
    cmd_kind_t        kind;
    cmd_t             entry;
    logic             push;

    always_comb
    begin
        op_ok = 1'b1;
        case (opcode)
            OP_START:  kind = CMD_START;
            OP_RSTART: kind = CMD_RSTART;
            OP_WRITE:  kind = CMD_WRITE;
            OP_READ:   kind = CMD_READ;
            OP_STOP:   kind = CMD_STOP;
            default:
            begin
                kind  = CMD_STOP;
                op_ok = 1'b0;
            end
        endcase
        entry.kind         = kind;
        entry.data_byte    = data_byte;
        entry.nak_last     = nak_last;
        entry.line_samples = line_samples;
        entry.last_idx     = phase_last(kind);
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    // unused opcodes are taken and dropped, they make no phases
    assign push     = in_valid && in_ready && op_ok;
    assign q_valid  = (count_reg != '0);
    assign q_head   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= entry;
    end

endmodule

`default_nettype wire

// File: src/i2cm_phase_gen.sv
// i2cm_phase_gen: walks each queued command through its pin phases and
// holds the bus pin state; depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_phase_gen (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  wire i2cm_pkg::cmd_t q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              scl_level,
    output logic              sda_level,
    output logic              sda_drive,
    output logic              sample_point,
    output logic              last_phase,
    output logic [7:0]        read_byte,
    output logic              acked
);
    import i2cm_pkg::*;

    cmd_t             cmd_reg, cmd_next;
    logic             cmd_valid_reg, cmd_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             drv_reg, drv_next;
    logic             out_valid_reg, out_valid_next;
    logic             smp_reg, last_reg, ack_reg;
    logic [7:0]       rd_reg;
    act_t             act;
    logic             is_last;
    logic             advance;

    assign act     = phase_action(cmd_reg.kind, idx_reg, cmd_reg.data_byte,
                                  cmd_reg.nak_last);
    assign is_last = (idx_reg == cmd_reg.last_idx);
    assign advance = cmd_valid_reg && (!out_valid_reg || out_ready);
    // the next command loads while the last phase of this one goes out
    assign q_pop   = q_valid && (!cmd_valid_reg || (advance && is_last));

    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        if (advance)
        begin
            case (act.kind)
                ACT_SDA: sda_next = act.value;
                ACT_SCL: scl_next = act.value;
                ACT_DIR: drv_next = act.value;
                default: sda_next = sda_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (advance)
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        if (advance && is_last)
            cmd_valid_next = 1'b0;
        if (q_pop)
        begin
            cmd_next       = q_head;
            cmd_valid_next = 1'b1;
        end
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drv_reg       <= drv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (advance)
        begin
            smp_reg  <= act.sample;
            last_reg <= is_last;
            ack_reg  <= is_last && (cmd_reg.kind != CMD_READ) && (cmd_reg.kind != CMD_STOP)
                        && !cmd_reg.line_samples[7];
            rd_reg   <= (is_last && (cmd_reg.kind == CMD_READ)) ? cmd_reg.line_samples : 8'h00;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = scl_reg;
    assign sda_level    = sda_reg;
    assign sda_drive    = drv_reg;
    assign sample_point = smp_reg;
    assign last_phase   = last_reg;
    assign read_byte    = rd_reg;
    assign acked        = ack_reg;

endmodule

`default_nettype wire

// File: src/i2c_master_byte_sequencer.sv
// i2c master byte sequencer: a command takes 3 to 34 phases, one per unstalled cycle
// an accepted command passes the queue entry, command register and output registers
// the phase generator emits one phase per unstalled cycle; a queued command follows
// with no gap; the two-entry queue takes new commands while a run is in progress
// reset: pins idle with scl high, sda high and driven; queue and output empty
// depends on i2cm_pkg, i2cm_front, i2cm_phase_gen
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] data_byte,
    input  wire logic       nak_last,
    input  wire logic [7:0] line_samples,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_level,
    output logic            sda_level,
    output logic            sda_drive,
    output logic            sample_point,
    output logic            last_phase,
    output logic [7:0]      read_byte,
    output logic            acked
);
    import i2cm_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .nak_last     (nak_last),
        .line_samples (line_samples),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop)
    );

    i2cm_phase_gen u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .sda_drive    (sda_drive),
        .sample_point (sample_point),
        .last_phase   (last_phase),
        .read_byte    (read_byte),
        .acked        (acked)
    );

endmodule

`default_nettype wire

// File: src/i2cm_checker.sv
// i2cm_checker: port level checks on the phase output, bound to the top level
// depends on i2c_master_byte_sequencer
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       scl_level,
    input wire logic       sda_drive,
    input wire logic       sample_point,
    input wire logic       last_phase,
    input wire logic [7:0] read_byte,
    input wire logic       acked
);

    // a stalled transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // sda is only sampled with scl high and the line released
    a_sample_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_point |-> scl_level && !sda_drive)
        else $error("sample phase with scl low or sda driven");

    // status fields are zero outside the final phase
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_phase |-> read_byte == 8'h00 && !acked)
        else $error("status reported before last phase");

    // no run ends on a sample phase
    a_last_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_phase |-> !sample_point)
        else $error("last phase is a sample phase");

endmodule

bind i2c_master_byte_sequencer i2cm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scl_level    (scl_level),
    .sda_drive    (sda_drive),
    .sample_point (sample_point),
    .last_phase   (last_phase),
    .read_byte    (read_byte),
    .acked        (acked)
);

`default_nettype wire
